@@ hdl/bcrc_pkg.sv @@
`timescale 1ns / 1ps

package bcrc_pkg;

    localparam logic KIND_WRITE    = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    localparam logic MODE_ASCII  = 1'b0;
    localparam logic MODE_BINARY = 1'b1;

    localparam logic [1:0] END_MATCH     = 2'd0;
    localparam logic [1:0] END_TERM      = 2'd1;
    localparam logic [1:0] END_EXHAUSTED = 2'd2;

    localparam logic [7:0] TERM_BYTE = 8'hff;
    localparam int         RANGE_BIT = 7;
    localparam logic [6:0] INDEX_MAX = 7'd127;
    localparam int         ENTRY_W   = 9;

    typedef struct packed {
        logic       kind;
        logic [5:0] entry_index;
        logic [7:0] entry_value;
        logic       entry_flag;
        logic [7:0] subject_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [6:0] handler_index;
        logic [1:0] end_kind;
    } res_item_t;

endpackage

@@ hdl/bcrc_ram.sv @@
`timescale 1ns / 1ps

module bcrc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/byte_command_range_classifier_unit.sv @@
`timescale 1ns / 1ps

// Write items store one table entry and leave the block idle. A classify item
// walks the table from position 0, one entry per cycle through the single
// read port of the table RAM, visiting at most TABLE_ENTRIES entries; no new
// item is taken during the walk. The result goes to an output register, and
// the next item is accepted while it waits to be taken.

module byte_command_range_classifier_unit
    import bcrc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res,
    input  logic      cfg_wen,
    input  logic      cfg_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_POS = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t      state_reg, state_next;
    logic        mode_reg, mode_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic        pending_reg, pending_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  byte_reg, byte_next;
    logic [6:0]  ord_reg, ord_next;
    logic [1:0]  kind_reg, kind_next;
    logic        res_valid_reg, res_valid_next;
    res_item_t   res_reg, res_next;

    logic               cmd_take;
    logic               wr_en;
    logic [7:0]         wr_idx_ext;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [7:0]         rd_value;
    logic               rd_flag;
    logic [6:0]         ord_inc;
    logic               is_range;
    logic               finish;
    logic [1:0]         fin_kind;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_take   = cmd_valid && !cmd_stall;
    assign wr_idx_ext = 8'(cmd.entry_index);
    assign wr_en      = cmd_take && (cmd.kind == KIND_WRITE)
                        && (wr_idx_ext < 8'(TABLE_ENTRIES));
    assign rd_value   = rd_data[7:0];
    assign rd_flag    = rd_data[8];
    assign ord_inc    = (ord_reg == INDEX_MAX) ? ord_reg : ord_reg + 7'd1;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    bcrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_ext[AW-1:0]),
        .wr_data ({cmd.entry_flag, cmd.entry_value}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        pending_next   = pending_reg;
        lo_next        = lo_reg;
        byte_next      = byte_reg;
        ord_next       = ord_reg;
        kind_next      = kind_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_reg + AW'(1);
        is_range       = 1'b0;
        finish         = 1'b0;
        fin_kind       = END_MATCH;

        if (cfg_wen)
        begin
            mode_next = cfg_data;
        end

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && (cmd.kind == KIND_CLASSIFY))
                begin
                    state_next   = ST_SCAN;
                    pos_next     = '0;
                    pending_next = 1'b0;
                    ord_next     = '0;
                    byte_next    = cmd.subject_byte;
                    rd_en        = 1'b1;
                    rd_addr      = '0;
                end
            end
            ST_SCAN:
            begin
                if (pending_reg)
                begin
                    if ((mode_reg == MODE_BINARY) && rd_flag)
                    begin
                        finish   = 1'b1;
                        fin_kind = END_TERM;
                    end
                    else if ((byte_reg >= lo_reg) && (byte_reg <= rd_value))
                    begin
                        finish   = 1'b1;
                        fin_kind = END_MATCH;
                    end
                    else
                    begin
                        ord_next     = ord_inc;
                        pending_next = 1'b0;
                    end
                end
                else if ((mode_reg == MODE_ASCII) && (rd_value == TERM_BYTE))
                begin
                    finish   = 1'b1;
                    fin_kind = END_TERM;
                end
                else
                begin
                    is_range = (mode_reg == MODE_ASCII) ? rd_value[RANGE_BIT] : rd_flag;
                    if (is_range)
                    begin
                        if (pos_reg == LAST_POS)
                        begin
                            finish   = 1'b1;
                            fin_kind = END_EXHAUSTED;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                            lo_next = (mode_reg == MODE_ASCII) ? {1'b0, rd_value[6:0]}
                                                               : rd_value;
                        end
                    end
                    else if (byte_reg == rd_value)
                    begin
                        finish   = 1'b1;
                        fin_kind = END_MATCH;
                    end
                    else
                    begin
                        ord_next = ord_inc;
                    end
                end

                if (!finish && (pos_reg == LAST_POS))
                begin
                    finish   = 1'b1;
                    fin_kind = END_EXHAUSTED;
                end

                if (finish)
                begin
                    state_next = ST_DONE;
                    kind_next  = fin_kind;
                end
                else
                begin
                    rd_en    = 1'b1;
                    pos_next = pos_reg + AW'(1);
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next         = 1'b1;
                    res_next.handler_index = ord_reg;
                    res_next.end_kind      = kind_reg;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_ASCII;
            pos_reg       <= '0;
            pending_reg   <= 1'b0;
            lo_reg        <= '0;
            byte_reg      <= '0;
            ord_reg       <= '0;
            kind_reg      <= END_MATCH;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            pending_reg   <= pending_next;
            lo_reg        <= lo_next;
            byte_reg      <= byte_next;
            ord_reg       <= ord_next;
            kind_reg      <= kind_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

@@ hdl/bcrc_checker.sv @@
`timescale 1ns / 1ps

module bcrc_checker
    import bcrc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_stall,
    input cmd_item_t cmd,
    input logic      res_valid,
    input logic      res_stall,
    input res_item_t res
);

    // A result that is held back stays put.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result item changed");

    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.end_kind == END_MATCH) || (res.end_kind == END_TERM)
                      || (res.end_kind == END_EXHAUSTED))
        else $error("result item carries an unused end kind");

    // A classify item occupies the block while the table is walked.
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.kind == KIND_CLASSIFY) |=> cmd_stall)
        else $error("item accepted right after a classify item");

    // A table write leaves the block free for the next item.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.kind == KIND_WRITE) |=> !cmd_stall)
        else $error("block busy after a table write");

endmodule

bind byte_command_range_classifier_unit bcrc_checker u_bcrc_checker (.*);
